/* hdl/esu_pkg.sv */
// Shared types, character codes and a hex digit helper function for the string unescaper.
package esu_pkg;

  typedef enum logic [1:0] {
    PH_TEXT = 2'd0,
    PH_ESC  = 2'd1,
    PH_HEX  = 2'd2,
    PH_DROP = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_CUT_ESC = 3'd1,
    ST_BAD_HEX = 3'd2,
    ST_CUT_UNI = 3'd3,
    ST_BAD_CP  = 3'd4,
    ST_UNKNOWN = 3'd5
  } status_t;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_UC_U   = 8'h55;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_UC_E   = 8'h45;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;

  localparam logic [3:0] SHORT_DIGITS = 4'd4;
  localparam logic [3:0] LONG_DIGITS  = 4'd8;

  localparam logic [31:0] CP_MAX       = 32'h0010_FFFF;
  localparam logic [31:0] SURR_LO      = 32'h0000_D800;
  localparam logic [31:0] SURR_HI      = 32'h0000_DFFF;

  // Bit 4 set means the character is a hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

/* hdl/escaped_string_unescaper_top.sv */
// Top level of the escaped string unescaper: decode logic and result buffer.
//
// Usage
//   Input channel (in_valid/in_ready): one raw byte of an escaped string per
//   transfer, with in_last on the final byte and in_mode selecting literal (0)
//   or IRI (1) rules. Result channel (out_valid/out_ready): one decoded byte
//   or one status item per transfer; out_run_last marks the last result of an
//   input byte and out_string_end the last result of a string.
//   Each accepted byte is decoded in the cycle it is taken and its zero to
//   four results are loaded into a four-entry result buffer, so the first
//   result appears in the cycle after the input transfer.
//   Throughput: one input per cycle while each input gives at most one result
//   and the receiver is ready. An input giving several results (UTF-8 from \u
//   or \U, or %3E from \> in IRI mode) holds the buffer until all have left;
//   the buffer drain sets the rate. A new input is taken in the same cycle the
//   final buffered result leaves. When the receiver stalls, the buffer holds
//   its results and in_ready drops while it holds any result.
//   Reset (rst_n low, synchronous) empties the buffer and returns the parser
//   to normal text with a cleared code point accumulator.
module escaped_string_unescaper_top
  import esu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       in_mode,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_run_last,
  output logic       out_string_end,
  output logic [2:0] out_status
);

  // Parser state
  phase_t      phase_r, phase_nxt;
  logic        eight_r, eight_nxt;
  logic [3:0]  dig_r, dig_nxt;
  logic [31:0] acc_r, acc_nxt;

  // Result buffer
  logic [7:0]  ob_byte_r [4];
  logic [7:0]  ob_byte_nxt [4];
  logic [2:0]  ob_rem_r;
  logic [1:0]  ob_idx_r;
  logic        ob_fin_r;
  logic        ob_has_r;
  status_t     ob_stat_r;

  // Decode outputs
  logic [2:0]  dec_cnt;
  logic        dec_fail;
  status_t     dec_err;
  logic [4:0]  hv;
  logic [3:0]  need;
  logic [3:0]  dig_inc;
  logic [31:0] acc_sh;
  logic        cp_bad;

  logic        in_xfer;
  logic        out_xfer;

  assign out_valid = (ob_rem_r != 3'd0);
  assign out_xfer  = out_valid && out_ready;
  // Take a new byte when the buffer is empty or its final result leaves now.
  assign in_ready  = (ob_rem_r == 3'd0) || ((ob_rem_r == 3'd1) && out_ready);
  assign in_xfer   = in_valid && in_ready;

  assign out_has_byte   = ob_has_r;
  assign out_byte       = ob_has_r ? ob_byte_r[ob_idx_r] : 8'd0;
  assign out_run_last   = (ob_rem_r == 3'd1);
  assign out_string_end = out_run_last && ob_fin_r;
  assign out_status     = ob_stat_r;

  assign hv      = hex_digit(in_byte);
  assign need    = eight_r ? LONG_DIGITS : SHORT_DIGITS;
  assign dig_inc = dig_r + 4'd1;
  assign acc_sh  = {acc_r[27:0], hv[3:0]};
  assign cp_bad  = (acc_sh > CP_MAX) || ((acc_sh >= SURR_LO) && (acc_sh <= SURR_HI));

  // Decode one input byte against the current parser state.
  always_comb begin
    phase_nxt = phase_r;
    eight_nxt = eight_r;
    dig_nxt   = dig_r;
    acc_nxt   = acc_r;
    dec_cnt   = 3'd0;
    dec_fail  = 1'b0;
    dec_err   = ST_OK;
    for (int k = 0; k < 4; k++) begin
      ob_byte_nxt[k] = 8'd0;
    end
    case (phase_r)
      PH_TEXT: begin
        if (in_byte == CH_BSLASH) begin
          if (in_last) begin
            dec_fail = 1'b1;
            dec_err  = ST_CUT_ESC;
          end else begin
            phase_nxt = PH_ESC;
          end
        end else begin
          ob_byte_nxt[0] = in_byte;
          dec_cnt        = 3'd1;
        end
      end
      PH_ESC: begin
        phase_nxt = PH_TEXT;
        if (in_byte == CH_BSLASH || (!in_mode && in_byte == CH_DQUOTE)) begin
          ob_byte_nxt[0] = in_byte;
          dec_cnt        = 3'd1;
        end else if (in_mode && in_byte == CH_GT) begin
          ob_byte_nxt[0] = CH_PCT;
          ob_byte_nxt[1] = CH_3;
          ob_byte_nxt[2] = CH_UC_E;
          dec_cnt        = 3'd3;
        end else if (in_byte == CH_LC_N) begin
          ob_byte_nxt[0] = CH_LF;
          dec_cnt        = 3'd1;
        end else if (in_byte == CH_LC_R) begin
          ob_byte_nxt[0] = CH_CR;
          dec_cnt        = 3'd1;
        end else if (in_byte == CH_LC_T) begin
          ob_byte_nxt[0] = CH_TAB;
          dec_cnt        = 3'd1;
        end else if (in_byte == CH_LC_U || in_byte == CH_UC_U) begin
          eight_nxt = (in_byte == CH_UC_U);
          dig_nxt   = 4'd0;
          acc_nxt   = 32'd0;
          if (in_last) begin
            dec_fail = 1'b1;
            dec_err  = ST_CUT_UNI;
          end else begin
            phase_nxt = PH_HEX;
          end
        end else begin
          dec_fail = 1'b1;
          dec_err  = ST_UNKNOWN;
        end
      end
      PH_HEX: begin
        if (!hv[4]) begin
          dec_fail = 1'b1;
          dec_err  = ST_BAD_HEX;
        end else begin
          acc_nxt = acc_sh;
          dig_nxt = dig_inc;
          if (dig_inc >= need) begin
            phase_nxt = PH_TEXT;
            if (cp_bad) begin
              dec_fail = 1'b1;
              dec_err  = ST_BAD_CP;
            end else if (acc_sh < 32'h80) begin
              ob_byte_nxt[0] = acc_sh[7:0];
              dec_cnt        = 3'd1;
            end else if (acc_sh < 32'h800) begin
              ob_byte_nxt[0] = {3'b110, acc_sh[10:6]};
              ob_byte_nxt[1] = {2'b10, acc_sh[5:0]};
              dec_cnt        = 3'd2;
            end else if (acc_sh < 32'h10000) begin
              ob_byte_nxt[0] = {4'b1110, acc_sh[15:12]};
              ob_byte_nxt[1] = {2'b10, acc_sh[11:6]};
              ob_byte_nxt[2] = {2'b10, acc_sh[5:0]};
              dec_cnt        = 3'd3;
            end else begin
              ob_byte_nxt[0] = {5'b11110, acc_sh[20:18]};
              ob_byte_nxt[1] = {2'b10, acc_sh[17:12]};
              ob_byte_nxt[2] = {2'b10, acc_sh[11:6]};
              ob_byte_nxt[3] = {2'b10, acc_sh[5:0]};
              dec_cnt        = 3'd4;
            end
          end else if (in_last) begin
            dec_fail = 1'b1;
            dec_err  = ST_CUT_UNI;
          end
        end
      end
      default: begin
        // Drop bytes until the string ends.
      end
    endcase
    if (dec_fail) begin
      phase_nxt = PH_DROP;
      dec_cnt   = 3'd1;
    end
    // The final byte of a string always returns the parser to its start.
    if (in_last) begin
      phase_nxt = PH_TEXT;
      eight_nxt = 1'b0;
      dig_nxt   = 4'd0;
      acc_nxt   = 32'd0;
    end
  end

  // Parser state advances only on an input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TEXT;
      eight_r <= 1'b0;
      dig_r   <= 4'd0;
      acc_r   <= 32'd0;
    end else if (in_xfer) begin
      phase_r <= phase_nxt;
      eight_r <= eight_nxt;
      dig_r   <= dig_nxt;
      acc_r   <= acc_nxt;
    end
  end

  // Result buffer control: load on input transfer, advance on output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ob_rem_r <= 3'd0;
      ob_idx_r <= 2'd0;
    end else if (in_xfer) begin
      ob_rem_r <= dec_cnt;
      ob_idx_r <= 2'd0;
    end else if (out_xfer) begin
      ob_rem_r <= ob_rem_r - 3'd1;
      ob_idx_r <= ob_idx_r + 2'd1;
    end
  end

  // Result buffer payload: hold until the next input transfer.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      for (int k = 0; k < 4; k++) begin
        ob_byte_r[k] <= ob_byte_nxt[k];
      end
      ob_fin_r  <= in_last || dec_fail;
      ob_has_r  <= !dec_fail;
      ob_stat_r <= dec_err;
    end
  end

`ifndef SYNTH
  // A status item is always the single, string-ending result of its input.
  a_status_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_byte) |-> (out_run_last && out_string_end))
    else $error("status item not marked as run and string end");

  // Data bytes never carry an error code.
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_has_byte) |-> (out_status == ST_OK))
    else $error("data byte with nonzero status");

  // The final byte of a string leaves the parser in normal text.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> (phase_r == PH_TEXT && acc_r == 32'd0))
    else $error("parser state not cleared after end of string");

  // The buffer never holds more than four results.
  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ob_rem_r <= 3'd4))
    else $error("result buffer count out of range");
`endif

endmodule

/* dv/escaped_string_unescaper_top_tb.sv */
// Self-checking testbench for the escaped string unescaper: random strings, stalls, scoreboard.
module escaped_string_unescaper_top_tb
  import esu_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer on either channel before the run is called hung.
  // Legal quiet stretches are bounded by the longest sender gap or receiver
  // stall plus the buffer drain.
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_BYTES = 350;
  localparam int MAX_PRINTS = 30;

  // One raw byte as handed to the input channel.
  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       mode;
    bit         drain_first;  // hold this byte back until every result is out
  } raw_item_t;

  // One decoded result as it should leave the result channel.
  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       run_last;
    logic       str_end;
    status_t    status;
  } unesc_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       in_mode = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_run_last;
  logic       out_string_end;
  logic [2:0] out_status;

  escaped_string_unescaper_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_byte       (in_byte),
    .in_last       (in_last),
    .in_mode       (in_mode),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .out_has_byte  (out_has_byte),
    .out_run_last  (out_run_last),
    .out_string_end(out_string_end),
    .out_status    (out_status)
  );

  always #5ns clk = ~clk;

  // Bytes waiting to be sent, and decoded results waiting to come out.
  raw_item_t     raw_q[$];
  unesc_result_t pending_results[$];
  logic [7:0]    str_buf[$];

  // Shadow copy of the decoder state.
  phase_t      unesc_phase = PH_TEXT;
  logic        long_form = 1'b0;
  logic [3:0]  digit_cnt = 4'd0;
  logic [31:0] code_acc = 32'd0;

  logic in_fire = 1'b0;
  logic out_fire = 1'b0;
  int   idle_cycles = 0;
  int   send_gap = 0;
  int   sink_hold = 0;
  bit   src_calm = 1'b0;
  bit   sink_calm = 1'b0;

  int mismatches = 0;
  int strings_built = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int status_seen = 0;
  int multi_result_inputs = 0;

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("%0t ns  mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Value of a hex digit character, or -1 for anything else.
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);   // 0-9
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h37);   // A-F
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h57);   // a-f
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'h30 + v;
    return (upper ? 8'h37 : 8'h57) + v;
  endfunction

  // Short gaps dominate, with the odd long one; calm stretches have none.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // Code point for a \u (wide = 0) or \U (wide = 1) escape; bad ones are
  // surrogates or, for the long form, values past the Unicode range.
  function automatic logic [31:0] pick_cp(input bit wide, input bit bad);
    logic [31:0] cp;
    if (bad) begin
      if (wide && $urandom_range(0, 1)) return $urandom_range(32'hFFFF_FFFF, 32'h0011_0000);
      return $urandom_range(SURR_HI, SURR_LO);
    end
    if ($urandom_range(0, 9) == 0) return wide ? CP_MAX : 32'h0000_FFFF;
    case ($urandom_range(0, wide ? 3 : 2))
      0: cp = $urandom_range(32'h7F, 32'h0);
      1: cp = $urandom_range(32'h7FF, 32'h80);
      2: begin
        do cp = $urandom_range(32'hFFFF, 32'h800);
        while (cp >= SURR_LO && cp <= SURR_HI);
      end
      default: cp = $urandom_range(CP_MAX, 32'h1_0000);
    endcase
    return cp;
  endfunction

  // Work out the results of one accepted byte and advance the shadow state.
  task automatic decode_byte(input logic [7:0] ch, input logic fin, input logic iri);
    logic [7:0]    outb[4];
    int            n;
    int            nib;
    bit            failed;
    status_t       err;
    unesc_result_t r;
    n = 0;
    failed = 1'b0;
    err = ST_OK;
    case (unesc_phase)
      PH_TEXT: begin
        if (ch == CH_BSLASH) begin
          if (fin) begin
            err = ST_CUT_ESC;
            failed = 1'b1;
          end else begin
            unesc_phase = PH_ESC;
          end
        end else begin
          outb[0] = ch;
          n = 1;
        end
      end
      PH_ESC: begin
        unesc_phase = PH_TEXT;
        if (ch == CH_BSLASH || (!iri && ch == CH_DQUOTE)) begin
          outb[0] = ch;
          n = 1;
        end else if (iri && ch == CH_GT) begin
          outb[0] = CH_PCT;
          outb[1] = CH_3;
          outb[2] = CH_UC_E;
          n = 3;
        end else if (ch == CH_LC_N) begin
          outb[0] = CH_LF;
          n = 1;
        end else if (ch == CH_LC_R) begin
          outb[0] = CH_CR;
          n = 1;
        end else if (ch == CH_LC_T) begin
          outb[0] = CH_TAB;
          n = 1;
        end else if (ch == CH_LC_U || ch == CH_UC_U) begin
          long_form = (ch == CH_UC_U);
          digit_cnt = 4'd0;
          code_acc = 32'd0;
          if (fin) begin
            err = ST_CUT_UNI;
            failed = 1'b1;
          end else begin
            unesc_phase = PH_HEX;
          end
        end else begin
          err = ST_UNKNOWN;
          failed = 1'b1;
        end
      end
      PH_HEX: begin
        nib = hex_nibble(ch);
        if (nib < 0) begin
          err = ST_BAD_HEX;
          failed = 1'b1;
        end else begin
          code_acc = {code_acc[27:0], nib[3:0]};
          digit_cnt = digit_cnt + 4'd1;
          if (digit_cnt >= (long_form ? LONG_DIGITS : SHORT_DIGITS)) begin
            unesc_phase = PH_TEXT;
            if (code_acc > CP_MAX || (code_acc >= SURR_LO && code_acc <= SURR_HI)) begin
              err = ST_BAD_CP;
              failed = 1'b1;
            end else if (code_acc < 32'h80) begin
              outb[0] = code_acc[7:0];
              n = 1;
            end else if (code_acc < 32'h800) begin
              outb[0] = {3'b110, code_acc[10:6]};
              outb[1] = {2'b10, code_acc[5:0]};
              n = 2;
            end else if (code_acc < 32'h1_0000) begin
              outb[0] = {4'b1110, code_acc[15:12]};
              outb[1] = {2'b10, code_acc[11:6]};
              outb[2] = {2'b10, code_acc[5:0]};
              n = 3;
            end else begin
              outb[0] = {5'b11110, code_acc[20:18]};
              outb[1] = {2'b10, code_acc[17:12]};
              outb[2] = {2'b10, code_acc[11:6]};
              outb[3] = {2'b10, code_acc[5:0]};
              n = 4;
            end
          end else if (fin) begin
            err = ST_CUT_UNI;
            failed = 1'b1;
          end
        end
      end
      default: ;  // dropping the rest of a failed string
    endcase

    if (failed) begin
      r = '{data: 8'h00, has_data: 1'b0, run_last: 1'b1, str_end: 1'b1, status: err};
      pending_results.insert(pending_results.size(), r);
      unesc_phase = PH_DROP;
    end else begin
      for (int k = 0; k < n; k++) begin
        r = '{data: outb[k], has_data: 1'b1, run_last: (k == n - 1),
              str_end: (k == n - 1) && fin, status: ST_OK};
        pending_results.insert(pending_results.size(), r);
      end
      if (n > 1) multi_result_inputs++;
    end
    // Every string end wipes the parser back to plain text.
    if (fin) begin
      unesc_phase = PH_TEXT;
      long_form = 1'b0;
      digit_cnt = 4'd0;
      code_acc = 32'd0;
    end
  endtask

  // Append one character to the string under construction.
  function automatic void add_char(input logic [7:0] c);
    str_buf.insert(str_buf.size(), c);
  endfunction

  // Append ndig hex digits of v, most significant first, in mixed case.
  task automatic add_hex(input logic [31:0] v, input int ndig);
    for (int i = ndig - 1; i >= 0; i--) add_char(hex_char(v[i*4 +: 4], 1'($urandom_range(0, 1))));
  endtask

  // Move the string under construction into the send queue.
  task automatic commit_string(input logic m, input bit pause, input bit mixed_mode);
    raw_item_t it;
    for (int i = 0; i < str_buf.size(); i++) begin
      it.ch = str_buf[i];
      it.last = (i == str_buf.size() - 1);
      it.mode = mixed_mode ? logic'($urandom_range(0, 1)) : m;
      it.drain_first = pause && (i == 0);
      raw_q.insert(raw_q.size(), it);
    end
    strings_built++;
    str_buf.delete();
  endtask

  // Build one random string: mostly well-formed escapes with random content,
  // some errors (which make the tail get dropped), and some raw noise.
  task automatic build_random_string();
    logic [7:0] c;
    logic       m;
    int         ntok;
    int         t;
    int         need;
    bit         wide;
    bit         ended;
    m = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 8) begin
      repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
      commit_string(m, 1'b0, 1'b1);
      return;
    end
    ntok = $urandom_range(1, 6);
    ended = 1'b0;
    for (int k = 0; k < ntok && !ended; k++) begin
      t = $urandom_range(0, 99);
      wide = 1'($urandom_range(0, 1));
      need = wide ? 8 : 4;
      if (t < 40) begin
        do c = 8'($urandom_range(0, 255));
        while (c == CH_BSLASH);
        add_char(c);
      end else if (t < 62) begin
        add_char(CH_BSLASH);
        case ($urandom_range(0, 4))
          0: add_char(CH_BSLASH);
          1: add_char(CH_LC_N);
          2: add_char(CH_LC_R);
          3: add_char(CH_LC_T);
          default: add_char(m ? CH_GT : CH_DQUOTE);
        endcase
      end else if (t < 88) begin
        add_char(CH_BSLASH);
        add_char(wide ? CH_UC_U : CH_LC_U);
        add_hex(pick_cp(wide, 1'b0), need);
      end else begin
        add_char(CH_BSLASH);
        case ($urandom_range(0, 4))
          0: begin
            // escape letter that this mode does not know
            if ($urandom_range(0, 1)) begin
              c = m ? CH_DQUOTE : CH_GT;
            end else begin
              do c = 8'($urandom_range(0, 255));
              while (c == CH_BSLASH || c == CH_LC_N || c == CH_LC_R || c == CH_LC_T ||
                     c == CH_LC_U || c == CH_UC_U || c == (m ? CH_GT : CH_DQUOTE));
            end
            add_char(c);
          end
          1: begin
            add_char(wide ? CH_UC_U : CH_LC_U);
            add_hex($urandom, $urandom_range(0, need - 1));
            do c = 8'($urandom_range(0, 255));
            while (hex_nibble(c) >= 0);
            add_char(c);
          end
          2: begin
            add_char(wide ? CH_UC_U : CH_LC_U);
            add_hex(pick_cp(wide, 1'b1), need);
          end
          default: begin
            // cut the string short inside the escape
            if ($urandom_range(0, 2) != 0) begin
              add_char(wide ? CH_UC_U : CH_LC_U);
              add_hex($urandom, $urandom_range(0, need - 1));
            end
            ended = 1'b1;
          end
        endcase
      end
    end
    commit_string(m, $urandom_range(0, 11) == 0, 1'b0);
  endtask

  // Input driver: change the payload at the falling edge; advance only after
  // the previous byte went through, then wait out a random gap.
  always @(negedge clk) begin : feed_bytes
    raw_item_t nxt;
    logic      drive_valid;
    if (rst_n) begin
      drive_valid = in_valid;
      if (!in_valid || in_fire) begin
        drive_valid = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (raw_q.size() != 0 &&
                     !(raw_q[0].drain_first && pending_results.size() != 0)) begin
          nxt = raw_q.pop_front();
          in_byte <= nxt.ch;
          in_last <= nxt.last;
          in_mode <= nxt.mode;
          drive_valid = 1'b1;
          if ($urandom_range(0, 99) < 4) src_calm = !src_calm;
          send_gap = pick_gap(src_calm);
        end
      end
      in_valid <= drive_valid;
    end
  end

  // Result receiver: stall at random, with calm stretches of full speed.
  always @(negedge clk) begin : pace_results
    if (rst_n) begin
      if (sink_hold > 0) begin
        sink_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 4) sink_calm = !sink_calm;
        if ($urandom_range(0, 99) < 35) sink_hold = pick_gap(sink_calm);
      end
    end
  end

  // Monitor: at each rising edge check the result transfer against the
  // oldest expectation first, then predict from the input transfer. A result
  // is always registered after its input transfer, so this order is safe.
  always @(posedge clk) begin : watch_ports
    unesc_result_t want;
    logic          in_go;
    logic          out_go;
    if (rst_n) begin
      in_go = in_valid && in_ready;
      out_go = out_valid && out_ready;
      if (out_go) begin
        results_seen++;
        if (!out_has_byte) status_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: byte %02h has %0b status %0d",
                                    out_byte, out_has_byte, out_status));
        end else begin
          want = pending_results.pop_front();
          if (out_byte !== want.data)
            report_mismatch($sformatf("result %0d out_byte %02h, want %02h",
                                      results_seen, out_byte, want.data));
          if (out_has_byte !== want.has_data)
            report_mismatch($sformatf("result %0d out_has_byte %0b, want %0b",
                                      results_seen, out_has_byte, want.has_data));
          if (out_run_last !== want.run_last)
            report_mismatch($sformatf("result %0d out_run_last %0b, want %0b",
                                      results_seen, out_run_last, want.run_last));
          if (out_string_end !== want.str_end)
            report_mismatch($sformatf("result %0d out_string_end %0b, want %0b",
                                      results_seen, out_string_end, want.str_end));
          if (out_status !== want.status)
            report_mismatch($sformatf("result %0d out_status %0d, want %0d",
                                      results_seen, out_status, want.status));
        end
      end
      if (in_go) begin
        bytes_sent++;
        decode_byte(in_byte, in_last, in_mode);
      end
      in_fire <= in_go;
      out_fire <= out_go;
      // Watchdog: a long run of cycles with no transfer at all means a hang.
      if (in_go || out_go) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Timed out after %0d cycles without a transfer", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // Directed strings: byte extremes with \" in literal mode.
    str_buf = '{8'h00, CH_BSLASH, CH_DQUOTE, 8'hFF};
    commit_string(1'b0, 1'b0, 1'b0);
    // IRI mode: \> expands to three bytes, then \t closes the string.
    str_buf = '{CH_BSLASH, CH_GT, CH_BSLASH, CH_LC_T};
    commit_string(1'b1, 1'b0, 1'b0);
    // Lone backslash as the final byte.
    str_buf = '{CH_BSLASH};
    commit_string(1'b0, 1'b0, 1'b0);
    // Escape letter u as the final byte.
    str_buf = '{CH_BSLASH, CH_LC_U};
    commit_string(1'b1, 1'b0, 1'b0);
    // Surrogate code point, then a byte that must be dropped; wait for a
    // fully drained block first.
    str_buf = '{CH_BSLASH, CH_LC_U, 8'h44, 8'h38, 8'h30, 8'h30, 8'h78};
    commit_string(1'b0, 1'b1, 1'b0);
    // Non-hex character on the final byte of a \u escape.
    str_buf = '{CH_BSLASH, CH_LC_U, 8'h30, 8'h67};
    commit_string(1'b1, 1'b0, 1'b0);
    // \> is unknown in literal mode; the trailing byte is dropped.
    str_buf = '{CH_BSLASH, CH_GT, 8'h61};
    commit_string(1'b0, 1'b0, 1'b0);

    while (raw_q.size() < RANDOM_BYTES + 25) build_random_string();

    // Hold reset, then release it off the falling edge.
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (raw_q.size() != 0 || in_valid) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    // Let any stray extra result show up before closing.
    repeat (8) @(posedge clk);

    $display("Sent %0d strings (%0d bytes, both modes, all escape forms and error kinds);",
             strings_built, bytes_sent);
    $display("checked %0d results: %0d status items, %0d bytes that expanded to several.",
             results_seen, status_seen, multi_result_inputs);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, pending_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
